FILE: rtl/rsod_pkg.sv
// shared types and constants for the rle scanline opcode decoder
// no dependencies
`timescale 1ns / 1ps

package rsod_pkg;

   localparam logic [7:0] KEPT_CHANNELS = 8'd3;

   localparam logic [5:0] OP_SKIP_LINES  = 6'd1;
   localparam logic [5:0] OP_SET_COLOR   = 6'd2;
   localparam logic [5:0] OP_SKIP_PIXELS = 6'd3;
   localparam logic [5:0] OP_BYTE_DATA   = 6'd5;
   localparam logic [5:0] OP_RUN_DATA    = 6'd6;
   localparam logic [5:0] OP_EOF         = 6'd7;

   typedef enum logic [1:0] {
      EV_SPAN      = 2'd0,
      EV_ROW_END   = 2'd1,
      EV_END_IMAGE = 2'd2,
      EV_UNKNOWN   = 2'd3
   } event_type;

   typedef enum logic [7:0] {
      PH_OPCODE    = 8'b0000_0001,
      PH_OPDATA    = 8'b0000_0010,
      PH_LONG_LO   = 8'b0000_0100,
      PH_LONG_HI   = 8'b0000_1000,
      PH_LITERALS  = 8'b0001_0000,
      PH_LIT_PAD   = 8'b0010_0000,
      PH_RUN_VALUE = 8'b0100_0000,
      PH_RUN_PAD   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [1:0]  channel_number;
      logic [15:0] start_x;
      logic [16:0] span_length;
      logic [7:0]  pixel_value;
      logic [15:0] lines_advanced;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] stream_byte;
      logic       restart;
   } step_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } emit_type;

endpackage

FILE: rtl/rsod_req_if.sv
// request channel: one encoded stream byte with restart flag
// no dependencies
`timescale 1ns / 1ps

interface rsod_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       restart;

   modport source (output valid, output stream_byte, output restart, input ready);
   modport sink (input valid, input stream_byte, input restart, output ready);
endinterface

FILE: rtl/rsod_rsp_if.sv
// result channel: one decoded event
// no dependencies
`timescale 1ns / 1ps

interface rsod_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [1:0]  channel_number;
   logic [15:0] start_x;
   logic [16:0] span_length;
   logic [7:0]  pixel_value;
   logic [15:0] lines_advanced;

   modport source (output valid, output event_kind, output channel_number, output start_x,
                   output span_length, output pixel_value, output lines_advanced,
                   input ready);
   modport sink (input valid, input event_kind, input channel_number, input start_x,
                 input span_length, input pixel_value, input lines_advanced,
                 output ready);
endinterface

FILE: rtl/rsod_parser.sv
// parser state and single-byte step logic of the rle opcode decoder
// depends on rsod_pkg
`timescale 1ns / 1ps

module rsod_parser
   import rsod_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  step_type step,
   output emit_type result
);

   phase_type   phase_ff, phase_in, phase_eff;
   logic [5:0]  held_ff, held_in, held_eff;
   logic        long_ff, long_in, long_eff;
   logic [7:0]  oplow_ff, oplow_in, oplow_eff;
   logic [16:0] left_ff, left_in, left_eff;
   logic        pad_ff, pad_in, pad_eff;
   logic [7:0]  chan_ff, chan_in, chan_eff;
   logic [15:0] column_ff, column_in, column_eff;
   logic        ended_ff, ended_in, ended_eff;

   logic        kept;
   logic        exec_go;
   logic [15:0] operand;
   logic [16:0] left_dec;
   logic [7:0]  b;

   always_comb begin
      b = step.stream_byte;

      phase_eff  = phase_ff;
      held_eff   = held_ff;
      long_eff   = long_ff;
      oplow_eff  = oplow_ff;
      left_eff   = left_ff;
      pad_eff    = pad_ff;
      chan_eff   = chan_ff;
      column_eff = column_ff;
      ended_eff  = ended_ff;
      if (step.valid && step.restart) begin
         phase_eff  = PH_OPCODE;
         held_eff   = '0;
         long_eff   = 1'b0;
         oplow_eff  = '0;
         left_eff   = '0;
         pad_eff    = 1'b0;
         chan_eff   = '0;
         column_eff = '0;
         ended_eff  = 1'b0;
      end

      phase_in  = phase_eff;
      held_in   = held_eff;
      long_in   = long_eff;
      oplow_in  = oplow_eff;
      left_in   = left_eff;
      pad_in    = pad_eff;
      chan_in   = chan_eff;
      column_in = column_eff;
      ended_in  = ended_eff;

      result   = '0;
      exec_go  = 1'b0;
      operand  = '0;
      left_dec = left_eff - 17'd1;
      kept     = chan_eff < KEPT_CHANNELS;

      if (step.valid && !ended_eff) begin
         unique case (phase_eff)
            PH_OPCODE: begin
               held_in  = b[5:0];
               long_in  = b[6];
               phase_in = PH_OPDATA;
            end
            PH_OPDATA: begin
               if (long_eff && (held_eff == OP_SKIP_LINES || held_eff == OP_SKIP_PIXELS ||
                                held_eff == OP_BYTE_DATA || held_eff == OP_RUN_DATA)) begin
                  phase_in = PH_LONG_LO;
               end else begin
                  exec_go = 1'b1;
                  operand = {8'd0, b};
               end
            end
            PH_LONG_LO: begin
               oplow_in = b;
               phase_in = PH_LONG_HI;
            end
            PH_LONG_HI: begin
               exec_go = 1'b1;
               operand = {b, oplow_eff};
            end
            PH_LITERALS: begin
               if (kept) begin
                  result.valid               = 1'b1;
                  result.data.event_kind     = EV_SPAN;
                  result.data.channel_number = chan_eff[1:0];
                  result.data.start_x        = column_eff;
                  result.data.span_length    = 17'd1;
                  result.data.pixel_value    = b;
               end
               column_in = column_eff + 16'd1;
               left_in   = left_dec;
               if (left_dec == 17'd0) begin
                  phase_in = pad_eff ? PH_LIT_PAD : PH_OPCODE;
               end
            end
            PH_LIT_PAD: begin
               pad_in   = 1'b0;
               phase_in = PH_OPCODE;
            end
            PH_RUN_VALUE: begin
               if (kept) begin
                  result.valid               = 1'b1;
                  result.data.event_kind     = EV_SPAN;
                  result.data.channel_number = chan_eff[1:0];
                  result.data.start_x        = column_eff;
                  result.data.span_length    = left_eff;
                  result.data.pixel_value    = b;
               end
               column_in = column_eff + left_eff[15:0];
               left_in   = '0;
               phase_in  = PH_RUN_PAD;
            end
            default: begin
               pad_in   = 1'b0;
               phase_in = PH_OPCODE;
            end
         endcase

         if (exec_go) begin
            phase_in = PH_OPCODE;
            unique case (held_eff)
               OP_SKIP_LINES: begin
                  column_in                  = '0;
                  result.valid               = 1'b1;
                  result.data.event_kind     = EV_ROW_END;
                  result.data.lines_advanced = (operand == 16'd0) ? 16'd1 : operand;
               end
               OP_SET_COLOR: begin
                  chan_in   = operand[7:0];
                  column_in = '0;
               end
               OP_SKIP_PIXELS: begin
                  column_in = column_eff + operand;
               end
               OP_BYTE_DATA: begin
                  left_in  = {1'b0, operand} + 17'd1;
                  pad_in   = ~operand[0];
                  phase_in = PH_LITERALS;
               end
               OP_RUN_DATA: begin
                  left_in  = {1'b0, operand} + 17'd1;
                  pad_in   = 1'b1;
                  phase_in = PH_RUN_VALUE;
               end
               OP_EOF: begin
                  ended_in               = 1'b1;
                  result.valid           = 1'b1;
                  result.data.event_kind = EV_END_IMAGE;
               end
               default: begin
                  result.valid           = 1'b1;
                  result.data.event_kind = EV_UNKNOWN;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPCODE;
         held_ff   <= '0;
         long_ff   <= 1'b0;
         oplow_ff  <= '0;
         left_ff   <= '0;
         pad_ff    <= 1'b0;
         chan_ff   <= '0;
         column_ff <= '0;
         ended_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         long_ff   <= long_in;
         oplow_ff  <= oplow_in;
         left_ff   <= left_in;
         pad_ff    <= pad_in;
         chan_ff   <= chan_in;
         column_ff <= column_in;
         ended_ff  <= ended_in;
      end
   end

endmodule

FILE: rtl/rle_scanline_opcode_decoder.sv
// top level of the rle scanline opcode decoder: input register, parser, result queue
// depends on rsod_pkg, rsod_req_if, rsod_rsp_if, rsod_parser
`timescale 1ns / 1ps

// usage
// req carries one byte of the encoded image body per request, with restart
// set to clear the parser, channel, column and end flag before that byte.
// rsp carries at most one event per request: pixel span, row end, end of
// image or unknown opcode; fields that do not apply to an event are zero.
// a request is held in the input register until the queue has room; it is
// then parsed, and its event is written into the queue and offered on rsp.
// throughput: one request per cycle while rsp takes events, set by the
// parser step and the two-entry result queue.
// a stalled rsp leaves events in the two-entry queue; req keeps being
// accepted while the queue has room, and ready drops once it is full and
// the input register holds a request that is not yet parsed.
// reset (synchronous, active high) empties the input register and queue
// and returns the parser to waiting for an opcode on channel zero, column
// zero.

module rle_scanline_opcode_decoder
   import rsod_pkg::*;
(
   input logic       clock,
   input logic       reset,
   rsod_req_if.sink  req,
   rsod_rsp_if.source rsp
);

   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_restart_ff;

   result_type q_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   logic       pop;
   logic       space;
   logic       s1_fire;
   logic       push;
   step_type   step;
   emit_type   result;
   result_type head;

   assign pop     = rsp.valid && rsp.ready;
   assign space   = (count_ff != 2'd2) || pop;
   assign s1_fire = s1_valid_ff && space;
   assign req.ready = !s1_valid_ff || s1_fire;

   assign step.valid       = s1_fire;
   assign step.stream_byte = s1_byte_ff;
   assign step.restart     = s1_restart_ff;

   rsod_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .result (result)
   );

   assign push = result.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         count_ff    <= '0;
      end else begin
         if (req.ready) begin
            s1_valid_ff <= req.valid;
         end
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         s1_byte_ff    <= req.stream_byte;
         s1_restart_ff <= req.restart;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= result.data;
      end
   end

   assign head = q_ff[rd_ptr_ff];

   assign rsp.valid          = count_ff != 2'd0;
   assign rsp.event_kind     = head.event_kind;
   assign rsp.channel_number = head.channel_number;
   assign rsp.start_x        = head.start_x;
   assign rsp.span_length    = head.span_length;
   assign rsp.pixel_value    = head.pixel_value;
   assign rsp.lines_advanced = head.lines_advanced;

endmodule

FILE: test/rle_scanline_opcode_decoder_tb.sv
// testbench for the rle scanline opcode decoder: random and directed byte streams
// with a self-contained event predictor and in-order event checking
// depends on rsod_pkg, rsod_req_if, rsod_rsp_if, rle_scanline_opcode_decoder
`timescale 1ns / 1ps

module rle_scanline_opcode_decoder_tb;
   import rsod_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int HOLD_CYCLES = 300;
   localparam logic [5:0] OP_UNUSED = 6'h3f;

   class decoded_event_board;
      result_type expected_events[$];
      int mismatches;

      phase_type phase;
      logic [5:0] opcode;
      logic long_form;
      logic [7:0] operand_low;
      logic [16:0] bytes_left;
      logic pad_pending;
      logic [7:0] channel;
      logic [15:0] column;
      logic ended;

      function new();
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         phase = PH_OPCODE;
         opcode = '0;
         long_form = 1'b0;
         operand_low = '0;
         bytes_left = '0;
         pad_pending = 1'b0;
         channel = '0;
         column = '0;
         ended = 1'b0;
      endfunction

      function void push_event(event_type kind, logic [1:0] ch, logic [15:0] x,
                               logic [16:0] len, logic [7:0] val, logic [15:0] lines);
         result_type e;
         e.event_kind = kind;
         e.channel_number = ch;
         e.start_x = x;
         e.span_length = len;
         e.pixel_value = val;
         e.lines_advanced = lines;
         expected_events.push_back(e);
      endfunction

      function void run_operation(logic [15:0] operand);
         phase = PH_OPCODE;
         case (opcode)
            OP_SKIP_LINES: begin
               column = '0;
               push_event(EV_ROW_END, 2'd0, 16'd0, 17'd0, 8'd0,
                          (operand == 16'd0) ? 16'd1 : operand);
            end
            OP_SET_COLOR: begin
               channel = operand[7:0];
               column = '0;
            end
            OP_SKIP_PIXELS: column = column + operand;
            OP_BYTE_DATA: begin
               bytes_left = {1'b0, operand} + 17'd1;
               pad_pending = bytes_left[0];
               phase = PH_LITERALS;
            end
            OP_RUN_DATA: begin
               bytes_left = {1'b0, operand} + 17'd1;
               pad_pending = 1'b1;
               phase = PH_RUN_VALUE;
            end
            OP_EOF: begin
               ended = 1'b1;
               push_event(EV_END_IMAGE, 2'd0, 16'd0, 17'd0, 8'd0, 16'd0);
            end
            default: push_event(EV_UNKNOWN, 2'd0, 16'd0, 17'd0, 8'd0, 16'd0);
         endcase
      endfunction

      function void take_stream_byte(logic [7:0] b, logic restart);
         logic kept;
         if (restart)
            clear();
         if (ended)
            return;
         kept = (channel < KEPT_CHANNELS);
         case (phase)
            PH_OPCODE: begin
               opcode = b[5:0];
               long_form = b[6];
               phase = PH_OPDATA;
            end
            PH_OPDATA: begin
               if (long_form && (opcode inside {OP_SKIP_LINES, OP_SKIP_PIXELS,
                                                OP_BYTE_DATA, OP_RUN_DATA}))
                  phase = PH_LONG_LO;
               else
                  run_operation({8'h00, b});
            end
            PH_LONG_LO: begin
               operand_low = b;
               phase = PH_LONG_HI;
            end
            PH_LONG_HI: run_operation({b, operand_low});
            PH_LITERALS: begin
               if (kept)
                  push_event(EV_SPAN, channel[1:0], column, 17'd1, b, 16'd0);
               column = column + 16'd1;
               bytes_left = bytes_left - 17'd1;
               if (bytes_left == 17'd0)
                  phase = pad_pending ? PH_LIT_PAD : PH_OPCODE;
            end
            PH_RUN_VALUE: begin
               if (kept)
                  push_event(EV_SPAN, channel[1:0], column, bytes_left, b, 16'd0);
               column = column + bytes_left[15:0];
               bytes_left = '0;
               phase = PH_RUN_PAD;
            end
            default: begin
               pad_pending = 1'b0;
               phase = PH_OPCODE;
            end
         endcase
      endfunction

      function void check_decoded(result_type got);
         result_type want;
         if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected event: kind %0d ch %0d x %0d len %0d val %0d lines %0d",
                        got.event_kind, got.channel_number, got.start_x,
                        got.span_length, got.pixel_value, got.lines_advanced);
            return;
         end
         want = expected_events.pop_front();
         if (got.event_kind !== want.event_kind || got.channel_number !== want.channel_number ||
             got.start_x !== want.start_x || got.span_length !== want.span_length ||
             got.pixel_value !== want.pixel_value ||
             got.lines_advanced !== want.lines_advanced) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch expected: kind %0d ch %0d x %0d len %0d val %0d lines %0d",
                        want.event_kind, want.channel_number, want.start_x,
                        want.span_length, want.pixel_value, want.lines_advanced);
               $display("           actual: kind %0d ch %0d x %0d len %0d val %0d lines %0d",
                        got.event_kind, got.channel_number, got.start_x,
                        got.span_length, got.pixel_value, got.lines_advanced);
            end
         end
      endfunction

      function int pending();
         return expected_events.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   rsod_req_if req_ch ();
   rsod_rsp_if rsp_ch ();

   rle_scanline_opcode_decoder dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   decoded_event_board decoded_events;
   int items_sent;
   int cycle_count;
   bit force_restart;
   bit random_restarts;
   bit calm;
   logic hold_off;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] value, input bit counted);
      int gap;
      int r;
      logic restart;
      restart = force_restart || (random_restarts && $urandom_range(0, 199) == 0);
      force_restart = 1'b0;
      gap = 0;
      if (!calm) begin
         r = $urandom_range(0, 99);
         if (r >= 95)
            gap = $urandom_range(8, 40);
         else if (r >= 65)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.stream_byte <= value;
      req_ch.restart <= restart;
      do
         @(posedge clock);
      while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
      decoded_events.take_stream_byte(value, restart);
      if (counted)
         items_sent++;
   endtask

   task automatic send_operation(input logic [5:0] op, input logic long_bit,
                                 input logic [15:0] operand);
      logic top_bit;
      top_bit = 1'($urandom_range(0, 1));
      send_byte({top_bit, long_bit, op}, 1'b1);
      if (long_bit && (op inside {OP_SKIP_LINES, OP_SKIP_PIXELS,
                                  OP_BYTE_DATA, OP_RUN_DATA})) begin
         send_byte(8'($urandom_range(0, 255)), 1'b1);
         send_byte(operand[7:0], 1'b1);
         send_byte(operand[15:8], 1'b1);
      end else begin
         send_byte(operand[7:0], 1'b1);
      end
   endtask

   task automatic random_sequence();
      int pick;
      int n;
      logic long_bit;
      logic [5:0] op;
      logic [15:0] operand;
      pick = $urandom_range(0, 99);
      long_bit = 1'($urandom_range(0, 1));
      operand = 16'($urandom_range(0, 65535));
      if (!long_bit)
         operand[15:8] = '0;
      if (pick < 10) begin
         if ($urandom_range(0, 4) == 0)
            operand = '0;
         send_operation(OP_SKIP_LINES, long_bit, operand);
      end else if (pick < 22) begin
         if ($urandom_range(0, 4) != 0)
            operand = 16'($urandom_range(0, 3));
         send_operation(OP_SET_COLOR, long_bit, operand);
      end else if (pick < 30) begin
         send_operation(OP_SKIP_PIXELS, long_bit, operand);
      end else if (pick < 60) begin
         n = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
         send_operation(OP_BYTE_DATA, long_bit, 16'(n - 1));
         repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b1);
         if (n % 2 == 1)
            send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 85) begin
         send_operation(OP_RUN_DATA, long_bit, operand);
         send_byte(8'($urandom_range(0, 255)), 1'b1);
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 89) begin
         do
            op = 6'($urandom_range(0, 63));
         while (op inside {OP_SKIP_LINES, OP_SET_COLOR, OP_SKIP_PIXELS,
                           OP_BYTE_DATA, OP_RUN_DATA, OP_EOF});
         send_operation(op, long_bit, operand);
      end else if (pick < 92) begin
         send_operation(OP_EOF, long_bit, operand);
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
         force_restart = 1'b1;
      end else begin
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   // receiver side: random stalls, calm stretches, and the long hold-off
   initial begin
      result_type got;
      int stall_left;
      int calm_left;
      int r;
      logic next_ready;
      stall_left = 0;
      calm_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.event_kind = rsp_ch.event_kind;
            got.channel_number = rsp_ch.channel_number;
            got.start_x = rsp_ch.start_x;
            got.span_length = rsp_ch.span_length;
            got.pixel_value = rsp_ch.pixel_value;
            got.lines_advanced = rsp_ch.lines_advanced;
            decoded_events.check_decoded(got);
         end
         next_ready = 1'b1;
         if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 10)
               calm_left = $urandom_range(20, 80);
            else if (r < 27)
               stall_left = $urandom_range(1, 3);
            else if (r < 30)
               stall_left = $urandom_range(8, 40);
         end
         if (hold_off)
            next_ready = 1'b0;
         rsp_ch.ready <= next_ready;
      end
   end

   // long hold-off while requests keep coming
   initial begin
      hold_off <= 1'b0;
      wait (items_sent >= 300);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      decoded_events = new();
      items_sent = 0;
      force_restart = 1'b0;
      random_restarts = 1'b0;
      calm = 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.stream_byte <= '0;
      req_ch.restart <= 1'b0;
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      force_restart = 1'b1;
      send_operation(OP_SKIP_LINES, 1'b0, 16'h0000);
      send_operation(OP_SKIP_LINES, 1'b1, 16'hffff);
      send_operation(OP_SKIP_PIXELS, 1'b1, 16'hffff);
      send_operation(OP_BYTE_DATA, 1'b0, 16'h0000);
      send_byte(8'hff, 1'b1);
      send_byte(8'h00, 1'b1);
      send_operation(OP_RUN_DATA, 1'b1, 16'hffff);
      send_byte(8'h00, 1'b1);
      send_byte(8'h55, 1'b1);
      send_operation(OP_SET_COLOR, 1'b1, 16'h0003);
      send_operation(OP_RUN_DATA, 1'b0, 16'h0000);
      send_byte(8'h11, 1'b1);
      send_byte(8'h22, 1'b1);
      send_operation(OP_UNUSED, 1'b1, 16'h0012);
      send_operation(OP_EOF, 1'b0, 16'h0000);
      send_byte({2'b00, OP_SKIP_LINES}, 1'b0);

      // random streams
      force_restart = 1'b1;
      random_restarts = 1'b1;
      while (items_sent < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 3) == 0);
         random_sequence();
      end
      calm = 1'b0;
      req_ch.valid <= 1'b0;

      while (decoded_events.pending() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (decoded_events.mismatches == 0 && decoded_events.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
